// ===== hdl/sqe_pkg.sv =====
// Package with shared types and constants for the stroke quad expander.
`default_nettype none
package sqe_pkg;

    // Clipping window limits.
    localparam logic signed [15:0] WIN_LO   = -16'sd400;
    localparam logic signed [15:0] WIN_X_HI = 16'sd720;
    localparam logic signed [15:0] WIN_Y_HI = 16'sd640;

    // Quotient bits (offset magnitude never exceeds the half-width).
    localparam int QW   = 10;
    // Length estimate width and product width.
    localparam int LW   = 11;
    localparam int PW   = 21;
    localparam int CW   = 12;

    // Side data carried along the divider chain.
    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [9:0]           slot;
        logic                 dx_neg;
        logic                 dx_nz;
        logic                 dy_pos;
        logic                 dy_nz;
    } side_t;

    // Divider state for both lanes.
    typedef struct packed {
        logic [PW-1:0] rem_x;
        logic [PW-1:0] rem_y;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
        logic [LW-1:0] len;
    } div_t;

endpackage
`default_nettype wire

// ===== hdl/sqe_front.sv =====
// Front end: window test, deltas, length estimate and offset products.
`default_nettype none
module sqe_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [111:0]    in_data,
    output logic                 out_valid,
    output sqe_pkg::side_t       out_side,
    output sqe_pkg::div_t        out_div
);

    logic signed [15:0] sx, sy, ex, ey;
    logic [9:0]         w;
    logic               outside;
    logic signed [16:0] dx, dy;
    logic [16:0]        mx17, my17;
    logic [sqe_pkg::LW-1:0] mx, my, len;
    sqe_pkg::side_t     side_next;

    logic               va_reg;
    sqe_pkg::side_t     side_a_reg;
    logic [sqe_pkg::LW-1:0] mx_a_reg, my_a_reg, len_a_reg;
    logic [9:0]         w_a_reg;

    logic               vb_reg;
    sqe_pkg::side_t     side_b_reg;
    sqe_pkg::div_t      div_b_reg;

    // Field unpacking and window test.
    always_comb begin
        sx = $signed(in_data[15:0]);
        sy = $signed(in_data[31:16]);
        ex = $signed(in_data[47:32]);
        ey = $signed(in_data[63:48]);
        w  = in_data[73:64];
        outside = (sx < sqe_pkg::WIN_LO) || (sx > sqe_pkg::WIN_X_HI) ||
                  (sy < sqe_pkg::WIN_LO) || (sy > sqe_pkg::WIN_Y_HI) ||
                  (ex < sqe_pkg::WIN_LO) || (ex > sqe_pkg::WIN_X_HI) ||
                  (ey < sqe_pkg::WIN_LO) || (ey > sqe_pkg::WIN_Y_HI);
    end

    // Deltas, magnitudes and the clamped length estimate.
    always_comb begin
        dx   = {ex[15], ex} - {sx[15], sx};
        dy   = {ey[15], ey} - {sy[15], sy};
        mx17 = dx[16] ? 17'(-dx) : 17'(dx);
        my17 = dy[16] ? 17'(-dy) : 17'(dy);
        mx   = mx17[sqe_pkg::LW-1:0];
        my   = my17[sqe_pkg::LW-1:0];
        if (mx > my) begin
            len = mx + (my >> 1);
        end else begin
            len = my + (mx >> 1);
        end
        if (len == '0) begin
            len = sqe_pkg::LW'(1);
        end
        side_next.ax     = sx[sqe_pkg::CW-1:0];
        side_next.ay     = sy[sqe_pkg::CW-1:0];
        side_next.bx     = ex[sqe_pkg::CW-1:0];
        side_next.by     = ey[sqe_pkg::CW-1:0];
        side_next.red    = in_data[81:74];
        side_next.green  = in_data[89:82];
        side_next.blue   = in_data[97:90];
        side_next.slot   = in_data[107:98];
        side_next.dx_neg = dx[16];
        side_next.dx_nz  = (dx != '0);
        side_next.dy_pos = !dy[16] && (dy != '0);
        side_next.dy_nz  = (dy != '0);
    end

    // Stage A: geometry registers; strokes outside the window drop here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid && !outside;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_a_reg <= side_next;
            mx_a_reg   <= mx;
            my_a_reg   <= my;
            len_a_reg  <= len;
            w_a_reg    <= w;
        end
    end

    // Stage B: one product per lane.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_b_reg      <= side_a_reg;
            div_b_reg.rem_x <= sqe_pkg::PW'(my_a_reg) * sqe_pkg::PW'(w_a_reg);
            div_b_reg.rem_y <= sqe_pkg::PW'(mx_a_reg) * sqe_pkg::PW'(w_a_reg);
            div_b_reg.q_x   <= '0;
            div_b_reg.q_y   <= '0;
            div_b_reg.len   <= len_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_side  = side_b_reg;
    assign out_div   = div_b_reg;

endmodule
`default_nettype wire

// ===== hdl/sqe_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit in both lanes.
`default_nettype none
module sqe_div_cell #(
    parameter int BIT = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire sqe_pkg::side_t in_side,
    input  wire sqe_pkg::div_t  in_div,
    output logic                out_valid,
    output sqe_pkg::side_t      out_side,
    output sqe_pkg::div_t       out_div
);

    logic [sqe_pkg::PW-1:0] dsh;
    sqe_pkg::div_t          div_next;
    logic                   valid_reg;
    sqe_pkg::side_t         side_reg;
    sqe_pkg::div_t          div_reg;

    // Compare against the shifted divisor and subtract where it fits.
    always_comb begin
        dsh      = sqe_pkg::PW'(in_div.len) << BIT;
        div_next = in_div;
        if (in_div.rem_x >= dsh) begin
            div_next.rem_x    = in_div.rem_x - dsh;
            div_next.q_x[BIT] = 1'b1;
        end
        if (in_div.rem_y >= dsh) begin
            div_next.rem_y    = in_div.rem_y - dsh;
            div_next.q_y[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

endmodule
`default_nettype wire

// ===== hdl/sqe_back.sv =====
// Back end: signs the offset, forms the four corners and holds the output.
`default_nettype none
module sqe_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire sqe_pkg::side_t in_side,
    input  wire sqe_pkg::div_t  in_div,
    output logic                out_valid,
    output logic [135:0]        out_data
);

    logic [sqe_pkg::QW-1:0]  qx, qy;
    logic signed [sqe_pkg::CW-1:0] px, py;
    logic [135:0]            data_next;
    logic                    valid_reg;
    logic [135:0]            data_reg;

    // A zero quotient with a nonzero delta becomes one pixel.
    always_comb begin
        qx = (in_div.q_x == '0 && in_side.dy_nz) ? sqe_pkg::QW'(1) : in_div.q_x;
        qy = (in_div.q_y == '0 && in_side.dx_nz) ? sqe_pkg::QW'(1) : in_div.q_y;
        px = in_side.dy_pos ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
        py = in_side.dx_neg ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    end

    // Corner assembly.
    always_comb begin
        data_next         = '0;
        data_next[11:0]   = in_side.ax + px;
        data_next[23:12]  = in_side.ay + py;
        data_next[35:24]  = in_side.bx + px;
        data_next[47:36]  = in_side.by + py;
        data_next[59:48]  = in_side.ax - px;
        data_next[71:60]  = in_side.ay - py;
        data_next[83:72]  = in_side.bx - px;
        data_next[95:84]  = in_side.by - py;
        data_next[103:96] = in_side.red;
        data_next[111:104] = in_side.green;
        data_next[119:112] = in_side.blue;
        data_next[129:120] = in_side.slot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== hdl/stroke_quad_expand_top.sv =====
// Top level of the stroke quad expander: front end, divider cell row, back end.
//
//  Channel | Direction | Beat contents
//  s_      | in        | stroke: endpoints, half-width, color, ordering slot
//  m_      | out       | quad: four corners, color, ordering slot
//
// One stroke is accepted per cycle while the output is not stalled. The stages are two
// front stages, ten divider cells at one quotient bit each, and one output register.
// Strokes outside the window leave a bubble and give no beat.
// Reset clears the valid bits of every stage; payload is not reset.
// A stalled output beat freezes the whole pipeline until it is taken.
`default_nettype none
module stroke_quad_expand_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // start_x, start_y, end_x, end_y, half_width, red_in, green_in, blue_in,
    // order_slot, zero fill
    input  wire logic [111:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // corner0_x..corner3_y (x then y per corner), red_out, green_out,
    // blue_out, slot_out, zero fill
    output logic [135:0]       m_tdata
);

    logic                 en;
    logic                 v_chain [sqe_pkg::QW+1];
    sqe_pkg::side_t       s_chain [sqe_pkg::QW+1];
    sqe_pkg::div_t        d_chain [sqe_pkg::QW+1];

    // The pipeline moves whenever the output slot is free or being taken.
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    sqe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (v_chain[0]),
        .out_side  (s_chain[0]),
        .out_div   (d_chain[0])
    );

    // Divider cells, most significant quotient bit first.
    for (genvar k = 0; k < sqe_pkg::QW; k++) begin : g_cell
        sqe_div_cell #(
            .BIT (sqe_pkg::QW - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_chain[k]),
            .in_side   (s_chain[k]),
            .in_div    (d_chain[k]),
            .out_valid (v_chain[k+1]),
            .out_side  (s_chain[k+1]),
            .out_div   (d_chain[k+1])
        );
    end

    sqe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_chain[sqe_pkg::QW]),
        .in_side   (s_chain[sqe_pkg::QW]),
        .in_div    (d_chain[sqe_pkg::QW]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // A held output beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Input is refused only while an output beat waits.
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without output stall");

    // No output beat right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== sim/tb_stroke_quad_expand_top.sv =====
// Self-checking testbench for the stroke quad expander top level.
`default_nettype none

// Holds the quads expected from the strokes accepted so far.
class quad_scoreboard;
    logic [135:0] quad_q[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    // Reports one mismatch on a single line and counts it.
    task report(input string what);
        $display("ERROR %0t: %s", $time, what);
        errors++;
    endtask

    // Works out the quad for an accepted stroke; strokes outside the window give none.
    function void note_stroke(input logic [111:0] d);
        logic signed [15:0] ax, ay, bx, by;
        longint w, dx, dy, mx, my, len, px, py;
        logic [11:0] c[8];
        ax = d[15:0];
        ay = d[31:16];
        bx = d[47:32];
        by = d[63:48];
        w  = d[73:64];
        if (ax < -400 || ax > 720 || ay < -400 || ay > 640 ||
            bx < -400 || bx > 720 || by < -400 || by > 640) return;
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        len = mx > my ? mx + (my >>> 1) : my + (mx >>> 1);
        if (len < 1) len = 1;
        px = (-dy * w) / len;
        py = (dx * w) / len;
        if (px == 0 && dy != 0) px = dy > 0 ? -1 : 1;
        if (py == 0 && dx != 0) py = dx > 0 ? 1 : -1;
        c[0] = ax + px; c[1] = ay + py; c[2] = bx + px; c[3] = by + py;
        c[4] = ax - px; c[5] = ay - py; c[6] = bx - px; c[7] = by - py;
        quad_q.push_back({2'b00, d[111:74], c[7], c[6], c[5], c[4],
                          c[3], c[2], c[1], c[0]});
    endfunction

    // Compares one output beat with the oldest expected quad.
    task check_quad(input logic [135:0] got);
        logic [135:0] exp_q;
        if (quad_q.size() == 0) begin
            report("output beat with no stroke pending");
            return;
        end
        exp_q = quad_q.pop_front();
        for (int i = 0; i < 8; i++)
            if (got[i*12 +: 12] !== exp_q[i*12 +: 12])
                report($sformatf("corner coordinate %0d: got %h, want %h",
                                 i, got[i*12 +: 12], exp_q[i*12 +: 12]));
        if (got[103:96] !== exp_q[103:96]) report("red_out mismatch");
        if (got[111:104] !== exp_q[111:104]) report("green_out mismatch");
        if (got[119:112] !== exp_q[119:112]) report("blue_out mismatch");
        if (got[129:120] !== exp_q[129:120]) report("slot_out mismatch");
        if (got[135:130] !== 6'd0) report("zero fill not zero");
    endtask
endclass

module tb_stroke_quad_expand_top;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         stim_done = 1'b0;

    quad_scoreboard quads = new();

    stroke_quad_expand_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Mostly short idle gaps, now and then a long one, often none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coordinate: mostly inside or near the window, sometimes anywhere.
    function automatic logic [15:0] coord(input bit is_y);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return is_y ? $urandom_range(0, 1040) - 400 : $urandom_range(0, 1120) - 400;
        if (r < 85) return $urandom_range(0, 20) + (is_y ? 630 : 710);
        if (r < 90) return -$urandom_range(390, 410);
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [111:0] pack_stroke(input logic [15:0] ax, ay, bx, by,
                                                 input logic [9:0] w,
                                                 input logic [7:0] r, g, b,
                                                 input logic [9:0] slot);
        return {38'd0, slot, b, g, r, w, by, bx, ay, ax};
    endfunction

    // Presents one stroke after a random gap and holds it until it is taken.
    task send_stroke(input logic [111:0] d);
        int g;
        g = gap_len();
        repeat (g) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quads.note_stroke(d);
        @(negedge aclk);
    endtask

    // Output side: random stalls, sampled at the rising edge.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                        (gap_len() == 0);
            @(posedge aclk);
            if (m_tvalid && m_tready) quads.check_quad(m_tdata);
        end
    end

    // Stimulus.
    initial begin
        logic [15:0] ax, ay;
        int n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        // Directed strokes: corners of the window, zero length, axis lines, edges.
        send_stroke(pack_stroke(-400, -400, 720, 640, 1023, 255, 0, 255, 0));
        send_stroke(pack_stroke(720, 640, -400, -400, 1023, 0, 255, 0, 1023));
        send_stroke(pack_stroke(100, 100, 100, 100, 1023, 1, 2, 3, 4));
        send_stroke(pack_stroke(0, 0, 500, 0, 7, 9, 9, 9, 9));
        send_stroke(pack_stroke(0, 0, 0, 500, 7, 9, 9, 9, 10));
        send_stroke(pack_stroke(0, 0, -500, 0, 0, 9, 9, 9, 11));
        send_stroke(pack_stroke(0, 0, 0, -500, 0, 9, 9, 9, 12));
        send_stroke(pack_stroke(0, 0, 700, 3, 1, 5, 6, 7, 13));
        send_stroke(pack_stroke(0, 0, -3, 600, 1, 5, 6, 7, 14));
        send_stroke(pack_stroke(-401, 0, 0, 0, 5, 1, 1, 1, 15));
        send_stroke(pack_stroke(0, 0, 721, 0, 5, 1, 1, 1, 16));
        send_stroke(pack_stroke(0, -401, 0, 0, 5, 1, 1, 1, 17));
        send_stroke(pack_stroke(0, 0, 0, 641, 5, 1, 1, 1, 18));
        send_stroke(pack_stroke(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 5, 1, 1, 1, 19));
        send_stroke(pack_stroke(16'hffff, 16'hffff, 16'hffff, 16'hffff, 512, 128, 128, 128, 512));
        send_stroke(pack_stroke(-400, 640, 720, -400, 1023, 170, 85, 170, 341));
        // Hold off until the pipeline has drained once.
        s_tvalid <= 1'b0;
        while (quads.quad_q.size() != 0) @(negedge aclk);
        // Random strokes, with short strokes common so the one-pixel forcing shows up.
        for (n = 0; n < 1650; n++) begin
            ax = coord(0);
            ay = coord(1);
            if ($urandom_range(0, 3) == 0)
                send_stroke(pack_stroke(ax, ay, ax + $urandom_range(0, 6) - 3,
                                        ay + $urandom_range(0, 6) - 3,
                                        $urandom_range(0, 1023), $urandom, $urandom,
                                        $urandom, $urandom_range(0, 1023)));
            else
                send_stroke(pack_stroke(ax, ay, coord(0), coord(1),
                                        $urandom_range(0, 1023), $urandom, $urandom,
                                        $urandom, $urandom_range(0, 1023)));
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Ending: drain, allow the pipeline latency, then decide.
    initial begin
        wait (stim_done);
        while (quads.quad_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (quads.errors == 0)
            $display("stroke_quad_expand_top test passed");
        else
            $display("stroke_quad_expand_top test failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("stroke_quad_expand_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
